@@ hw/rtl/broadcast_reshape_address_gen_assert.svh @@
// assertion macros shared by the address generator modules
`ifndef BROADCAST_RESHAPE_ADDRESS_GEN_ASSERT_SVH
`define BROADCAST_RESHAPE_ADDRESS_GEN_ASSERT_SVH

// same-cycle implication
`define BRAG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/brag_pkg.sv @@
`timescale 1ns / 1ps

package brag_pkg;

  localparam int NUM_AXES     = 7;
  localparam int LEN_BITS     = 8;
  localparam int MAX_ELEMENTS = 65536;

  localparam int ADDR_W   = 16;
  localparam int REG_W    = NUM_AXES * LEN_BITS;
  localparam int AXIS_W   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int CNT_W    = $clog2(MAX_ELEMENTS + 1);
  localparam int PROD_W   = CNT_W + LEN_BITS;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 2 * ADDR_W;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_LEN = 1'b1;

  localparam logic [REG_W-1:0] LEN_RESET = {NUM_AXES{{(LEN_BITS-1){1'b0}}, 1'b1}};
  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

  typedef struct packed {
    logic              clear;
    logic              init;
    logic              step;
    logic [AXIS_W-1:0] axis;
    logic              finish;
  } cmd_t;

endpackage

@@ hw/rtl/broadcast_reshape_address_gen.sv @@
`timescale 1ns / 1ps
// broadcast / reshape address generator
// walks every destination coordinate (axis 0 fastest) and emits one word per
// input word: clamped source flat address and destination flat address.
// input channel s_axis_*: tdata bit 0 is restart, which clears the
// coordinate counter before the word is formed.
// output channel m_axis_*: tdata holds source address (low) and destination
// address (high), tlast marks the final destination element, tuser the shape
// error flag (addresses zero, tlast set, counter cleared).
// configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 source lengths, 1 destination lengths); the user must write only while idle,
// which the block does not enforce. the multiply-accumulate unit visits one
// axis per cycle; no new input word is taken until the previous one is finished.
// a finished word waits in the output register; the next input word is taken
// meanwhile, and its result waits until the receiver takes the previous one.
// reset: counter cleared, all axis lengths 1, no word pending.

module broadcast_reshape_address_gen (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [brag_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [brag_pkg::REG_W-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [brag_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // restart
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [brag_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // source_address, target_address
  output logic                                m_axis_tlast,   // last_pair
  output logic                                m_axis_tuser    // shape_error
);

  brag_pkg::cmd_t              cmd;
  logic [brag_pkg::ADDR_W-1:0] src_addr, tgt_addr;

  brag_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_restart_i (s_axis_tdata[0]),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .cmd_o        (cmd)
  );

  brag_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .src_addr_o (src_addr),
    .tgt_addr_o (tgt_addr),
    .last_o     (m_axis_tlast),
    .err_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {tgt_addr, src_addr};

endmodule

@@ hw/rtl/brag_ctrl.sv @@
`timescale 1ns / 1ps
`include "broadcast_reshape_address_gen_assert.svh"

module brag_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_restart_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output brag_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StFinish
  } state_e;

  state_e                      state_q;
  logic [brag_pkg::AXIS_W-1:0] axis_q;
  logic                        out_valid_q;
  logic                        accept;
  logic                        load;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign load        = (state_q == StFinish) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.clear  = accept && in_restart_i;
    cmd_o.init   = accept;
    cmd_o.step   = (state_q == StCalc);
    cmd_o.axis   = axis_q;
    cmd_o.finish = load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            axis_q  <= '0;
            state_q <= StCalc;
          end
        end
        StCalc: begin
          if (axis_q == brag_pkg::LAST_AXIS) begin
            state_q <= StFinish;
          end else begin
            axis_q <= axis_q + 1'b1;
          end
        end
        StFinish: begin
          if (load) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `BRAG_ASSERT_NEXT(a_accept_starts_walk, accept, (state_q == StCalc) && (axis_q == '0),
    "accepted word did not start the axis walk")
  `BRAG_ASSERT_NEXT(a_last_axis_finishes, (state_q == StCalc) && (axis_q == brag_pkg::LAST_AXIS),
    state_q == StFinish, "axis walk did not end after the last axis")
  `BRAG_ASSERT_NEXT(a_finish_waits, (state_q == StFinish) && out_valid_q && !out_ready_i,
    (state_q == StFinish) && out_valid_q, "result overwritten while output stalled")

endmodule

@@ hw/rtl/brag_datapath.sv @@
`timescale 1ns / 1ps
`include "broadcast_reshape_address_gen_assert.svh"

module brag_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [brag_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [brag_pkg::REG_W-1:0]       cfg_data_i,
  input  brag_pkg::cmd_t                   cmd_i,
  output logic [brag_pkg::ADDR_W-1:0]      src_addr_o,
  output logic [brag_pkg::ADDR_W-1:0]      tgt_addr_o,
  output logic                             last_o,
  output logic                             err_o
);

  localparam int LB = brag_pkg::LEN_BITS;
  localparam int AW = brag_pkg::ADDR_W;
  localparam int PW = brag_pkg::PROD_W;
  localparam int NA = brag_pkg::NUM_AXES;
  localparam logic [PW-1:0] MAX_EL = PW'(brag_pkg::MAX_ELEMENTS);

  logic [brag_pkg::REG_W-1:0] src_len_q, tgt_len_q;
  logic [LB-1:0]              coord_q [NA];
  logic [LB-1:0]              coord_nx [NA];

  logic [AW-1:0]              zs_q, zt_q;
  logic [brag_pkg::CNT_W-1:0] ns_q, nt_q;
  logic                       bad_q;

  logic [AW-1:0]              src_addr_q, tgt_addr_q;
  logic                       last_q, err_q;

  logic [LB-1:0]    len_s, len_t, coord, cs, ct;
  logic [AW+LB-1:0] zs_prod, zt_prod;
  logic [PW-1:0]    ns_prod, nt_prod;
  logic             step_bad;
  logic             carry;

  function automatic logic [LB-1:0] clamp(input logic [LB-1:0] c, input logic [LB-1:0] len);
    logic [LB:0] lm1;
    lm1 = {1'b0, len} - 1'b1;
    clamp = ({1'b0, c} > lm1) ? lm1[LB-1:0] : c;
  endfunction

  // one axis per step, axis 0 outermost
  always_comb begin
    len_s    = src_len_q[cmd_i.axis*LB +: LB];
    len_t    = tgt_len_q[cmd_i.axis*LB +: LB];
    coord    = coord_q[cmd_i.axis];
    cs       = clamp(coord, len_s);
    ct       = clamp(coord, len_t);
    zs_prod  = zs_q * len_s;
    zt_prod  = zt_q * len_t;
    ns_prod  = ns_q * len_s;
    nt_prod  = nt_q * len_t;
    step_bad = (len_s == '0) || (len_t == '0) || (ns_prod > MAX_EL) || (nt_prod > MAX_EL);
  end

  // counter advance, axis 0 fastest
  always_comb begin
    carry = 1'b1;
    for (int i = 0; i < NA; i++) begin
      coord_nx[i] = coord_q[i];
      if (carry) begin
        if ({1'b0, coord_q[i]} >= ({1'b0, tgt_len_q[i*LB +: LB]} - 1'b1)) begin
          coord_nx[i] = '0;
        end else begin
          coord_nx[i] = coord_q[i] + LB'(1);
          carry       = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_len_q <= brag_pkg::LEN_RESET;
      tgt_len_q <= brag_pkg::LEN_RESET;
      for (int i = 0; i < NA; i++) begin
        coord_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          brag_pkg::REG_SRC_LEN: src_len_q <= cfg_data_i;
          brag_pkg::REG_TGT_LEN: tgt_len_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clear || (cmd_i.finish && bad_q)) begin
        for (int i = 0; i < NA; i++) begin
          coord_q[i] <= '0;
        end
      end else if (cmd_i.finish) begin
        for (int i = 0; i < NA; i++) begin
          coord_q[i] <= coord_nx[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      zs_q  <= '0;
      zt_q  <= '0;
      ns_q  <= brag_pkg::CNT_W'(1);
      nt_q  <= brag_pkg::CNT_W'(1);
      bad_q <= 1'b0;
    end else if (cmd_i.step) begin
      zs_q  <= zs_prod[AW-1:0] + AW'(cs);
      zt_q  <= zt_prod[AW-1:0] + AW'(ct);
      ns_q  <= ns_prod[brag_pkg::CNT_W-1:0];
      nt_q  <= nt_prod[brag_pkg::CNT_W-1:0];
      bad_q <= bad_q || step_bad;
    end
    if (cmd_i.finish) begin
      src_addr_q <= bad_q ? '0 : zs_q;
      tgt_addr_q <= bad_q ? '0 : zt_q;
      last_q     <= bad_q || carry;
      err_q      <= bad_q;
    end
  end

  assign src_addr_o = src_addr_q;
  assign tgt_addr_o = tgt_addr_q;
  assign last_o     = last_q;
  assign err_o      = err_q;

  `BRAG_ASSERT_NEXT(a_error_word, cmd_i.finish && bad_q,
    err_q && last_q && (src_addr_q == '0) && (tgt_addr_q == '0),
    "shape error word not formed as zero addresses with last set")
  `BRAG_ASSERT_NEXT(a_good_word, cmd_i.finish && !bad_q, !err_q,
    "error flag set on a valid shape")
  `BRAG_ASSERT_NOW(a_init_alone, cmd_i.init, !cmd_i.step && !cmd_i.finish,
    "init overlaps a step or a finish")

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import brag_pkg::*;

  localparam int ITEM_TOTAL = 1450;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] tgt_addr;
    logic              last_pair;
    logic              shape_error;
  } pair_t;

  typedef struct packed {
    logic             is_cfg;
    logic [REG_W-1:0] src_shape;
    logic [REG_W-1:0] tgt_shape;
    logic             restart;
    logic             typed;
    pair_t            want;
  } script_row_t;

  localparam pair_t SOLO_PAIR = '{16'd0, 16'd0, 1'b1, 1'b0};
  localparam pair_t ERR_PAIR  = '{16'd0, 16'd0, 1'b1, 1'b1};
  localparam pair_t NO_PAIR   = '{16'd0, 16'd0, 1'b0, 1'b0};

  localparam int SCRIPT_LEN = 28;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // one-element tables after reset
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b1, SOLO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b1, 1'b1, SOLO_PAIR},
    // zero source lengths
    '{1'b1, 56'h0, LEN_RESET, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b1, ERR_PAIR},
    // all source lengths at maximum, over the element limit
    '{1'b1, 56'hFFFFFFFFFFFFFF, LEN_RESET, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b1, 1'b1, ERR_PAIR},
    // destination over the limit
    '{1'b1, LEN_RESET, 56'h0101010102FFFF, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b1, ERR_PAIR},
    // destination exactly at the limit
    '{1'b1, 56'h010101010103FF, 56'h01010110101010, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b1, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b0, NO_PAIR},
    // broadcast 2 -> 3x2, full walk and wrap
    '{1'b1, 56'h01010101010102, 56'h01010101010203, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b1, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b0, NO_PAIR},
    // shrink axis 0 mid-walk, coordinate beyond the new length
    '{1'b1, 56'h01010101010102, 56'h01010101010201, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b0, NO_PAIR},
    // widest axes at both ends
    '{1'b1, 56'hFF010101010101, 56'hFF0101010101FF, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b1, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, LEN_RESET, LEN_RESET, 1'b0, 1'b0, NO_PAIR}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = REG_SRC_LEN;
  logic [REG_W-1:0]      cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  broadcast_reshape_address_gen dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // predictor state
  logic [REG_W-1:0]    src_shape = LEN_RESET;
  logic [REG_W-1:0]    tgt_shape = LEN_RESET;
  logic [LEN_BITS-1:0] walk_pos [NUM_AXES];

  pair_t pending_pairs [$];
  int    fail_count = 0;
  int    words_sent = 0;
  int    send_idle_pct = 21;
  int    recv_idle_pct = 49;
  bit    hold_request = 1'b0;
  int    cycle_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit shape_invalid(input logic [REG_W-1:0] shape);
    longint unsigned count;
    int unsigned len;
    count = 1;
    for (int a = 0; a < NUM_AXES; a++) begin
      len = shape[a*LEN_BITS +: LEN_BITS];
      if (len == 0) return 1'b1;
      count = count * len;
      if (count > MAX_ELEMENTS) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic longint unsigned flat_offset(input logic [REG_W-1:0] shape);
    longint unsigned z;
    int unsigned len;
    int unsigned c;
    z = 0;
    for (int a = 0; a < NUM_AXES; a++) begin
      len = shape[a*LEN_BITS +: LEN_BITS];
      c = walk_pos[a];
      if (c > len - 1) c = len - 1;
      z = z * len + c;
    end
    return z;
  endfunction

  function automatic pair_t next_pair(input logic restart_bit);
    pair_t p;
    int unsigned len;
    bit wrapped;
    p = NO_PAIR;
    wrapped = 1'b1;
    if (restart_bit) begin
      for (int a = 0; a < NUM_AXES; a++) walk_pos[a] = '0;
    end
    if (shape_invalid(src_shape) || shape_invalid(tgt_shape)) begin
      for (int a = 0; a < NUM_AXES; a++) walk_pos[a] = '0;
      return ERR_PAIR;
    end
    p.src_addr = ADDR_W'(flat_offset(src_shape));
    p.tgt_addr = ADDR_W'(flat_offset(tgt_shape));
    // axis 0 steps fastest
    for (int a = 0; a < NUM_AXES; a++) begin
      len = tgt_shape[a*LEN_BITS +: LEN_BITS];
      if (walk_pos[a] >= len - 1) begin
        walk_pos[a] = '0;
      end else begin
        walk_pos[a] = walk_pos[a] + 1'b1;
        wrapped = 1'b0;
        break;
      end
    end
    p.last_pair = wrapped;
    p.shape_error = 1'b0;
    return p;
  endfunction

  function automatic logic [REG_W-1:0] rand_shape();
    logic [REG_W-1:0] shape;
    int unsigned pick;
    shape = LEN_RESET;
    pick = $urandom_range(19);
    if (pick == 0) begin
      shape[$urandom_range(NUM_AXES-1)*LEN_BITS +: LEN_BITS] = LEN_BITS'($urandom_range(1, 4));
      shape[$urandom_range(NUM_AXES-1)*LEN_BITS +: LEN_BITS] = '0;
    end else if (pick == 1) begin
      for (int a = 0; a < 3; a++) begin
        shape[$urandom_range(a*2, a*2+1)*LEN_BITS +: LEN_BITS] =
          LEN_BITS'($urandom_range(128, 255));
      end
    end else if (pick < 6) begin
      shape[$urandom_range(NUM_AXES-1)*LEN_BITS +: LEN_BITS] = LEN_BITS'($urandom_range(1, 255));
      shape[$urandom_range(NUM_AXES-1)*LEN_BITS +: LEN_BITS] = LEN_BITS'($urandom_range(1, 3));
    end else begin
      repeat (3) begin
        shape[$urandom_range(NUM_AXES-1)*LEN_BITS +: LEN_BITS] = LEN_BITS'($urandom_range(1, 4));
      end
    end
    return shape;
  endfunction

  task automatic send_word(input logic restart_bit, input logic typed, input pair_t want);
    pair_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_DATA_W-1){1'b0}}, restart_bit};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = next_pair(restart_bit);
    pending_pairs.insert(pending_pairs.size(), typed ? want : predicted);
    words_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_shapes(input logic [REG_W-1:0] src, input logic [REG_W-1:0] tgt);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_SRC_LEN;
    cfg_data_i <= src;
    @(posedge clk_i);
    cfg_idx_i <= REG_TGT_LEN;
    cfg_data_i <= tgt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    src_shape = src;
    tgt_shape = tgt;
  endtask

  // receiver
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pair_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected word: tdata %h tlast %b tuser %b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        fail_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (m_axis_tdata[ADDR_W-1:0] !== want.src_addr) begin
          $error("source_address: expected %h, got %h", want.src_addr, m_axis_tdata[ADDR_W-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[2*ADDR_W-1:ADDR_W] !== want.tgt_addr) begin
          $error("target_address: expected %h, got %h",
                 want.tgt_addr, m_axis_tdata[2*ADDR_W-1:ADDR_W]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last_pair) begin
          $error("last_pair: expected %b, got %b", want.last_pair, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser !== want.shape_error) begin
          $error("shape_error: expected %b, got %b", want.shape_error, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("broadcast_reshape_address_gen test failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase_len;
    bit held;
    held = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) walk_pos[a] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].is_cfg) begin
        wait_idle();
        set_shapes(SCRIPT[i].src_shape, SCRIPT[i].tgt_shape);
      end else begin
        send_word(SCRIPT[i].restart, SCRIPT[i].typed, SCRIPT[i].want);
      end
    end

    while (words_sent < ITEM_TOTAL) begin
      if (words_sent < ITEM_TOTAL / 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 49;
      end else if (words_sent < 2 * ITEM_TOTAL / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_idle();
      set_shapes(rand_shape(), rand_shape());
      // one long receiver stall, in the first random phase only, while words keep coming
      if (!held) begin
        hold_request = 1'b1;
        held = 1'b1;
      end
      phase_len = $urandom_range(10, 60);
      repeat (phase_len) begin
        send_word($urandom_range(19) == 0, 1'b0, NO_PAIR);
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("broadcast_reshape_address_gen test passed");
    end else begin
      $display("broadcast_reshape_address_gen test failed");
    end
    $finish;
  end

endmodule
